// ===== hw/rtl/colinear_band_segment_merger_unit_defines.svh =====
// Assertion macros shared by the band segment merger RTL.
`ifndef COLINEAR_BAND_SEGMENT_MERGER_UNIT_DEFINES_SVH
`define COLINEAR_BAND_SEGMENT_MERGER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CBSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CBSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cbsm_pkg.sv =====
// Shared widths, payload types and output queue constants for the segment merger.
`default_nettype none
package cbsm_pkg;

	localparam int COORD_BITS = 31;
	localparam int BAND_BITS  = 16;

	// largest band-edge point difference is below 2^COORD_BITS + 2^(BAND_BITS+1)
	localparam longint DIFF_MAX = (64'd1 << COORD_BITS) + (64'd1 << (BAND_BITS + 1));
	localparam int PT_W   = $clog2(DIFF_MAX) + 1;
	localparam int PROD_W = 2 * PT_W;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [BAND_BITS-1:0]  band_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
		band_t  lo_band;
		band_t  hi_band;
		logic   group_end;
	} in_req_t;

	typedef struct packed {
		coord_t out_start_x;
		coord_t out_start_y;
		coord_t out_end_x;
		coord_t out_end_y;
		band_t  out_lo_band;
		band_t  out_hi_band;
		logic   out_last;
	} out_req_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
		band_t  lo_band;
		band_t  hi_band;
	} rect_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cbsm_merge_chk.sv =====
// Merge test: end-beyond-start overlap and colinearity of both band edge pairs.
`default_nettype none
module cbsm_merge_chk (
	input  cbsm_pkg::rect_t held,
	input  cbsm_pkg::rect_t cand,
	output logic            merge_ok
);

	typedef logic signed [cbsm_pkg::PT_W-1:0]   pt_t;
	typedef logic signed [cbsm_pkg::PROD_W-1:0] prod_t;

	// points a,b,c on one line: (ax-bx)*(by-cy) == (bx-cx)*(ay-by), exact
	function automatic logic col3(input pt_t ax, input pt_t ay, input pt_t bx,
		input pt_t by, input pt_t cx, input pt_t cy);
		prod_t lhs;
		prod_t rhs;
		pt_t   d0;
		pt_t   d1;
		pt_t   d2;
		pt_t   d3;
		d0  = ax - bx;
		d1  = by - cy;
		d2  = bx - cx;
		d3  = ay - by;
		lhs = d0 * d1;
		rhs = d2 * d3;
		return lhs == rhs;
	endfunction

	pt_t hsx, hsy, hex, hey, hbl, hbu;
	pt_t nsx, nsy, nex, ney, nbl, nbu;
	logic lower_ok, upper_ok, overlap;

	always_comb begin
		hsx = pt_t'(held.start_x);
		hsy = pt_t'(held.start_y);
		hex = pt_t'(held.end_x);
		hey = pt_t'(held.end_y);
		hbl = pt_t'(held.lo_band);
		hbu = pt_t'(held.hi_band);
		nsx = pt_t'(cand.start_x);
		nsy = pt_t'(cand.start_y);
		nex = pt_t'(cand.end_x);
		ney = pt_t'(cand.end_y);
		nbl = pt_t'(cand.lo_band);
		nbu = pt_t'(cand.hi_band);

		// lower edge: (sx, sy+b) -> (ex-b, ey)
		lower_ok = col3(hsx, hsy + hbl, hex - hbl, hey, nsx, nsy + nbl) &&
			col3(hex - hbl, hey, nsx, nsy + nbl, nex - nbl, ney);
		// upper edge: (sx+b, sy) -> (ex, ey-b)
		upper_ok = col3(hsx + hbu, hsy, hex, hey - hbu, nsx + nbu, nsy) &&
			col3(hex, hey - hbu, nsx + nbu, nsy, nex, ney - nbu);

		overlap  = (held.end_x > cand.start_x) && (held.end_y > cand.start_y);
		merge_ok = overlap && lower_ok && upper_ok;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cbsm_out_fifo.sv =====
// Result queue: takes up to two requests per cycle, hands out one per cycle while the reader is ready.
`default_nettype none
`include "colinear_band_segment_merger_unit_defines.svh"
module cbsm_out_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [1:0]                        push_cnt,
	input  cbsm_pkg::out_req_t                push_data [2],
	output logic [cbsm_pkg::OQ_CNT_W-1:0]     count,
	output logic                              head_valid,
	input  logic                              head_ready,
	output cbsm_pkg::out_req_t                head_req
);

	cbsm_pkg::out_req_t mem_q [cbsm_pkg::OQ_DEPTH];
	logic [cbsm_pkg::OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [cbsm_pkg::OQ_CNT_W-1:0] count_q;
	logic pop;

	assign head_valid = (count_q != '0);
	assign head_req   = mem_q[rd_ptr_q];
	assign pop        = head_valid && head_ready;
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push_data[0];
		end
		if (push_cnt == 2'd2) begin
			mem_q[cbsm_pkg::OQ_PTR_W'(wr_ptr_q + 1'b1)] <= push_data[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + cbsm_pkg::OQ_PTR_W'(push_cnt);
			rd_ptr_q <= rd_ptr_q + cbsm_pkg::OQ_PTR_W'(pop);
			count_q  <= count_q + cbsm_pkg::OQ_CNT_W'(push_cnt) - cbsm_pkg::OQ_CNT_W'(pop);
		end
	end

	`CBSM_ASSERT_NOW(a_oq_cnt_max, 1'b1, count_q <= cbsm_pkg::OQ_CNT_W'(cbsm_pkg::OQ_DEPTH), "queue count over depth")
	`CBSM_ASSERT_NOW(a_oq_push2_room, push_cnt == 2'd2, count_q <= cbsm_pkg::OQ_CNT_W'(cbsm_pkg::OQ_DEPTH - 2), "double push without room")
	`CBSM_ASSERT_NEXT(a_oq_hold, head_valid && !head_ready, head_valid && $stable(head_req), "waiting request lost")

endmodule
`default_nettype wire

// ===== hw/rtl/colinear_band_segment_merger_unit.sv =====
// Flow: a rectangle taken sits in the input register; its results are written to the
// result queue once the queue holds two requests or fewer.
// Throughput: one rectangle per cycle while the queue has room, set by the combinational
// merge test against the held rectangle; a rectangle that gives two results adds two
// requests to the queue; the input waits while the queue holds three or more requests.
// Reset: clears the held rectangle valid, the input register valid and the result queue.
`default_nettype none
`include "colinear_band_segment_merger_unit_defines.svh"
module colinear_band_segment_merger_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rect_valid,
	output logic                 rect_ready,
	input  cbsm_pkg::in_req_t    rect,
	output logic                 merged_valid,
	input  logic                 merged_ready,
	output cbsm_pkg::out_req_t   merged
);

	logic                          valid_s1;
	cbsm_pkg::in_req_t             rect_s1;
	logic                          held_valid_q;
	cbsm_pkg::rect_t               held_q;
	cbsm_pkg::rect_t               cand;
	cbsm_pkg::rect_t               nxt_held;
	logic                          merge_ok, merge, fire, emit_old, gend;
	logic [1:0]                    push_cnt;
	cbsm_pkg::out_req_t            push_data [2];
	cbsm_pkg::out_req_t            old_res, nxt_res;
	logic [cbsm_pkg::OQ_CNT_W-1:0] q_count;

	// room for two results keeps the worst case safe
	assign fire       = valid_s1 && (q_count <= cbsm_pkg::OQ_CNT_W'(cbsm_pkg::OQ_DEPTH - 2));
	assign rect_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rect_ready) begin
			valid_s1 <= rect_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rect_valid && rect_ready) begin
			rect_s1 <= rect;
		end
	end

	always_comb begin
		cand.start_x = rect_s1.start_x;
		cand.start_y = rect_s1.start_y;
		cand.end_x   = rect_s1.end_x;
		cand.end_y   = rect_s1.end_y;
		cand.lo_band = rect_s1.lo_band;
		cand.hi_band = rect_s1.hi_band;
	end

	cbsm_merge_chk u_chk (
		.held     (held_q),
		.cand     (cand),
		.merge_ok (merge_ok)
	);

	assign merge    = held_valid_q && merge_ok;
	assign emit_old = held_valid_q && !merge;
	assign gend     = rect_s1.group_end;

	always_comb begin
		nxt_held = cand;
		if (merge) begin
			nxt_held       = held_q;
			nxt_held.end_x = cand.end_x;
			nxt_held.end_y = cand.end_y;
		end
		old_res = '{held_q.start_x, held_q.start_y, held_q.end_x, held_q.end_y,
			held_q.lo_band, held_q.hi_band, 1'b0};
		nxt_res = '{nxt_held.start_x, nxt_held.start_y, nxt_held.end_x, nxt_held.end_y,
			nxt_held.lo_band, nxt_held.hi_band, 1'b1};
		push_data[0] = emit_old ? old_res : nxt_res;
		push_data[1] = nxt_res;
		push_cnt     = fire ? ({1'b0, emit_old} + {1'b0, gend}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
		end else if (fire) begin
			held_valid_q <= !gend;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			held_q <= nxt_held;
		end
	end

	cbsm_out_fifo u_oq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (push_cnt),
		.push_data  (push_data),
		.count      (q_count),
		.head_valid (merged_valid),
		.head_ready (merged_ready),
		.head_req   (merged)
	);

	`CBSM_ASSERT_NEXT(a_gend_clears, fire && gend, !held_valid_q, "held rectangle survives group end")
	`CBSM_ASSERT_NEXT(a_hold_sets, fire && !gend, held_valid_q, "no rectangle held after request")
	`CBSM_ASSERT_NEXT(a_merge_keeps_start, fire && merge, $stable(held_q.start_x) && $stable(held_q.lo_band), "merge altered held start")

endmodule
`default_nettype wire
